@@ src/stok_pkg.sv @@
// shared types, token codes and keyword tables for the source tokenizer
package stok_pkg;

   // scanner modes
   typedef enum logic [3:0] {
      MODE_IDLE    = 4'd0,
      MODE_COMMENT = 4'd1,
      MODE_INT     = 4'd2,
      MODE_DOT     = 4'd3,
      MODE_FRAC    = 4'd4,
      MODE_IDENT   = 4'd5,
      MODE_STRING  = 4'd6,
      MODE_OP      = 4'd7
   } mode_type;

   // token kinds
   localparam logic [5:0] KIND_NUMBER   = 6'd0;
   localparam logic [5:0] KIND_STRING   = 6'd1;
   localparam logic [5:0] KIND_IDENT    = 6'd5;
   localparam logic [5:0] KIND_AND      = 6'd21;
   localparam logic [5:0] KIND_OR       = 6'd22;
   localparam logic [5:0] KIND_NOT      = 6'd23;
   localparam logic [5:0] KIND_PLUS     = 6'd24;
   localparam logic [5:0] KIND_MINUS    = 6'd25;
   localparam logic [5:0] KIND_STAR     = 6'd26;
   localparam logic [5:0] KIND_SLASH    = 6'd27;
   localparam logic [5:0] KIND_PERCENT  = 6'd28;
   localparam logic [5:0] KIND_EQ       = 6'd29;
   localparam logic [5:0] KIND_EQEQ     = 6'd30;
   localparam logic [5:0] KIND_BANGEQ   = 6'd31;
   localparam logic [5:0] KIND_LT       = 6'd32;
   localparam logic [5:0] KIND_LTEQ     = 6'd33;
   localparam logic [5:0] KIND_GT       = 6'd34;
   localparam logic [5:0] KIND_GTEQ     = 6'd35;
   localparam logic [5:0] KIND_LPAREN   = 6'd36;
   localparam logic [5:0] KIND_RPAREN   = 6'd37;
   localparam logic [5:0] KIND_LBRACE   = 6'd38;
   localparam logic [5:0] KIND_RBRACE   = 6'd39;
   localparam logic [5:0] KIND_LBRACKET = 6'd40;
   localparam logic [5:0] KIND_RBRACKET = 6'd41;
   localparam logic [5:0] KIND_COMMA    = 6'd42;
   localparam logic [5:0] KIND_COLON    = 6'd43;
   localparam logic [5:0] KIND_DOT      = 6'd44;
   localparam logic [5:0] KIND_NEWLINE  = 6'd45;
   localparam logic [5:0] KIND_EOF      = 6'd46;
   localparam logic [5:0] KIND_ERROR    = 6'd47;

   // error codes
   localparam logic [1:0] ERR_STRING     = 2'd0;
   localparam logic [1:0] ERR_AMP        = 2'd1;
   localparam logic [1:0] ERR_BAR        = 2'd2;
   localparam logic [1:0] ERR_UNEXPECTED = 2'd3;
   localparam logic [1:0] ERR_NONE       = 2'd0;

   localparam logic [19:0] LINE_LIMIT  = 20'hFFFFF;
   localparam logic [3:0]  IDENT_LIMIT = 4'd15;
   localparam int          MAX_RESULTS = 3;

   // keyword table, empty slots have length zero
   localparam logic [79:0] KW_TEXT [32] = '{
      0: "else", 1: "bool", 2: "fn", 3: "false", 4: "float", 5: "if", 6: "impl",
      7: "implement", 8: "int", 9: "interface", 10: "list", 11: "map",
      12: "string", 13: "struct", 14: "null", 15: "return", 16: "true",
      17: "while", default: 80'd0};
   localparam logic [3:0] KW_LEN [32] = '{
      0: 4'd4, 1: 4'd4, 2: 4'd2, 3: 4'd5, 4: 4'd5, 5: 4'd2, 6: 4'd4, 7: 4'd9,
      8: 4'd3, 9: 4'd9, 10: 4'd4, 11: 4'd3, 12: 4'd6, 13: 4'd6, 14: 4'd4,
      15: 4'd6, 16: 4'd4, 17: 4'd5, default: 4'd0};
   localparam logic [5:0] KW_KIND [32] = '{
      0: 6'd15, 1: 6'd9, 2: 6'd12, 3: 6'd3, 4: 6'd7, 5: 6'd14, 6: 6'd19,
      7: 6'd20, 8: 6'd6, 9: 6'd18, 10: 6'd10, 11: 6'd11, 12: 6'd8, 13: 6'd17,
      14: 6'd4, 15: 6'd13, 16: 6'd2, 17: 6'd16, default: 6'd5};

   // one result beat
   typedef struct packed {
      logic [5:0]  token_kind;
      logic [1:0]  error_code;
      logic [19:0] start_offset;
      logic [20:0] token_length;
      logic [19:0] line_number;
      logic        last_of_run;
   } result_type;

   // results produced by one accepted byte
   typedef struct packed {
      logic [1:0]             count;
      result_type [MAX_RESULTS-1:0] res;
   } scan_out_type;

   // byte of keyword slot at position pos, pos below its length
   function automatic logic [7:0] kw_byte(input int slot, input logic [3:0] pos);
      logic [79:0] t;
      t = KW_TEXT[slot] >> (8 * (int'(KW_LEN[slot]) - 1 - int'(pos)));
      return t[7:0];
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   // one-byte punctuation, valid flag in the top bit
   function automatic logic [6:0] single_kind(input logic [7:0] c);
      case (c)
         "(": return {1'b1, KIND_LPAREN};
         ")": return {1'b1, KIND_RPAREN};
         "{": return {1'b1, KIND_LBRACE};
         "}": return {1'b1, KIND_RBRACE};
         "[": return {1'b1, KIND_LBRACKET};
         "]": return {1'b1, KIND_RBRACKET};
         ",": return {1'b1, KIND_COMMA};
         ":": return {1'b1, KIND_COLON};
         ".": return {1'b1, KIND_DOT};
         "+": return {1'b1, KIND_PLUS};
         "-": return {1'b1, KIND_MINUS};
         "*": return {1'b1, KIND_STAR};
         "/": return {1'b1, KIND_SLASH};
         "%": return {1'b1, KIND_PERCENT};
         default: return {1'b0, KIND_ERROR};
      endcase
   endfunction

   function automatic logic [5:0] op_single(input logic [7:0] h);
      case (h)
         "=": return KIND_EQ;
         "!": return KIND_NOT;
         "<": return KIND_LT;
         default: return KIND_GT;
      endcase
   endfunction

   function automatic logic [5:0] op_double(input logic [7:0] h);
      case (h)
         "=": return KIND_EQEQ;
         "!": return KIND_BANGEQ;
         "<": return KIND_LTEQ;
         default: return KIND_GTEQ;
      endcase
   endfunction

endpackage

@@ src/stok_scan.sv @@
// scanner state and per-byte token logic
module stok_scan #(
   parameter int SOURCE_BYTES  = 1048576,
   parameter int KEYWORD_COUNT = 19
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic [7:0]            ch,
   input  logic                  end_of_source,
   output stok_pkg::scan_out_type scan_out
);
   import stok_pkg::*;

   localparam int OW = $clog2(SOURCE_BYTES) + 1;
   localparam logic [OW-1:0] OFFSET_MAX = OW'(SOURCE_BYTES);
   localparam logic [OW-2:0] START_MAX  = (OW-1)'(SOURCE_BYTES - 1);
   localparam logic [OW:0]   SPAN_MAX   = (OW+1)'(SOURCE_BYTES);

   mode_type                 mode_ff, mode_in;
   logic [OW-2:0]            start_ff, start_in;
   logic [OW-1:0]            offset_ff, offset_in;
   logic [19:0]              line_ff, line_in;
   logic [KEYWORD_COUNT-1:0] cand_ff, cand_in;
   logic [3:0]               ilen_ff, ilen_in;
   logic [7:0]               held_ff, held_in;

   function automatic logic [OW-2:0] clamp(input logic [OW-1:0] p);
      return (p > OW'(START_MAX)) ? START_MAX : p[OW-2:0];
   endfunction

   function automatic logic [19:0] start_field(input logic [OW-2:0] s);
      logic [63:0] t;
      t = 64'(s);
      return t[19:0];
   endfunction

   function automatic logic [20:0] span(input logic [OW:0] hi, input logic [OW-2:0] lo);
      logic [OW:0]  d;
      logic [63:0]  t;
      d = (hi > (OW+1)'(lo)) ? hi - (OW+1)'(lo) : '0;
      if (d > SPAN_MAX) d = SPAN_MAX;
      t = 64'(d);
      return t[20:0];
   endfunction

   function automatic logic [KEYWORD_COUNT-1:0] feed(input logic [KEYWORD_COUNT-1:0] cand,
                                                   input logic [3:0] p, input logic [7:0] c);
      logic [KEYWORD_COUNT-1:0] r;
      r = cand;
      for (int i = 0; i < KEYWORD_COUNT; i++) begin
         if (p >= KW_LEN[i] || kw_byte(i, p) != c) r[i] = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [5:0] ident_kind(input logic [KEYWORD_COUNT-1:0] cand,
                                             input logic [3:0] len);
      logic [5:0] k;
      k = KIND_IDENT;
      for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
         if (cand[i] && KW_LEN[i] != 4'd0 && KW_LEN[i] == len) k = KW_KIND[i];
      end
      return k;
   endfunction

   function automatic result_type mk(input logic [5:0] kind, input logic [1:0] err,
                                     input logic [19:0] st, input logic [20:0] len,
                                     input logic [19:0] ln);
      result_type r;
      r.token_kind   = kind;
      r.error_code   = err;
      r.start_offset = st;
      r.token_length = len;
      r.line_number  = ln;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

   // per-byte scan: extend the open token, or close it and start a new one
   always_comb begin
      logic        fin;
      logic        taken;
      logic [OW-1:0] pos;
      logic [OW-1:0] dot;
      logic [2:0]  n;
      logic [6:0]  sk;
      result_type [MAX_RESULTS-1:0] res;

      mode_in   = mode_ff;
      start_in  = start_ff;
      offset_in = offset_ff;
      line_in   = line_ff;
      cand_in   = cand_ff;
      ilen_in   = ilen_ff;
      held_in   = held_ff;
      res       = '0;
      n         = 3'd0;
      taken     = 1'b0;
      fin       = end_of_source || ch == 8'd0;
      pos       = offset_ff;
      dot       = (pos != '0) ? pos - OW'(1) : '0;
      sk        = single_kind(ch);

      // extend the open token
      if (!fin) begin
         case (mode_ff)
            MODE_COMMENT: begin
               if (ch != 8'h0A) taken = 1'b1;
               else mode_in = MODE_IDLE;
            end
            MODE_INT: begin
               if (is_digit(ch)) taken = 1'b1;
               else if (ch == ".") begin
                  mode_in = MODE_DOT;
                  taken   = 1'b1;
               end
            end
            MODE_DOT: begin
               if (is_digit(ch)) begin
                  mode_in = MODE_FRAC;
                  taken   = 1'b1;
               end
            end
            MODE_FRAC: begin
               if (is_digit(ch)) taken = 1'b1;
            end
            MODE_IDENT: begin
               if (is_alpha(ch) || is_digit(ch) || ch == "_") begin
                  cand_in = feed(cand_ff, ilen_ff, ch);
                  ilen_in = (ilen_ff == IDENT_LIMIT) ? IDENT_LIMIT : ilen_ff + 4'd1;
                  taken   = 1'b1;
               end
            end
            MODE_STRING: begin
               taken = 1'b1;
               if (ch == "\"") begin
                  res[n[1:0]] = mk(KIND_STRING, ERR_NONE, start_field(start_ff),
                                   span((OW+1)'(pos) + (OW+1)'(1), start_ff), line_ff);
                  n = n + 3'd1;
                  mode_in = MODE_IDLE;
               end else if (ch == 8'h0A && line_ff < LINE_LIMIT) begin
                  line_in = line_ff + 20'd1;
               end
            end
            MODE_OP: begin
               if (held_ff == "&" || held_ff == "|") begin
                  if (ch == held_ff) begin
                     res[n[1:0]] = mk((ch == "&") ? KIND_AND : KIND_OR, ERR_NONE,
                                      start_field(start_ff), 21'd2, line_ff);
                     n = n + 3'd1;
                     mode_in = MODE_IDLE;
                     taken   = 1'b1;
                  end
               end else if (ch == "=") begin
                  res[n[1:0]] = mk(op_double(held_ff), ERR_NONE, start_field(start_ff),
                                   21'd2, line_ff);
                  n = n + 3'd1;
                  mode_in = MODE_IDLE;
                  taken   = 1'b1;
               end
            end
            default: mode_in = MODE_IDLE;
         endcase
      end

      // close the pending token
      if (fin || !taken) begin
         case (mode_ff)
            MODE_INT, MODE_FRAC: begin
               res[n[1:0]] = mk(KIND_NUMBER, ERR_NONE, start_field(start_ff),
                                span((OW+1)'(pos), start_ff), line_ff);
               n = n + 3'd1;
            end
            MODE_DOT: begin
               res[n[1:0]] = mk(KIND_NUMBER, ERR_NONE, start_field(start_ff),
                                span((OW+1)'(dot), start_ff), line_ff);
               n = n + 3'd1;
               res[n[1:0]] = mk(KIND_DOT, ERR_NONE, start_field(clamp(dot)), 21'd1,
                                line_ff);
               n = n + 3'd1;
            end
            MODE_IDENT: begin
               res[n[1:0]] = mk(ident_kind(cand_ff, ilen_ff), ERR_NONE,
                                start_field(start_ff), span((OW+1)'(pos), start_ff),
                                line_ff);
               n = n + 3'd1;
            end
            MODE_STRING: begin
               res[n[1:0]] = mk(KIND_ERROR, ERR_STRING, start_field(start_ff),
                                span((OW+1)'(pos), start_ff), line_ff);
               n = n + 3'd1;
            end
            MODE_OP: begin
               if (held_ff == "&")
                  res[n[1:0]] = mk(KIND_ERROR, ERR_AMP, start_field(start_ff), 21'd1,
                                   line_ff);
               else if (held_ff == "|")
                  res[n[1:0]] = mk(KIND_ERROR, ERR_BAR, start_field(start_ff), 21'd1,
                                   line_ff);
               else
                  res[n[1:0]] = mk(op_single(held_ff), ERR_NONE, start_field(start_ff),
                                   21'd1, line_ff);
               n = n + 3'd1;
            end
            default: ;
         endcase
         mode_in = MODE_IDLE;
      end

      if (fin) begin
         // end of source: eof beat, then back to reset state
         res[n[1:0]] = mk(KIND_EOF, ERR_NONE, start_field(clamp(pos)), 21'd0, line_ff);
         n = n + 3'd1;
         mode_in   = MODE_IDLE;
         start_in  = '0;
         offset_in = '0;
         line_in   = 20'd1;
         cand_in   = '1;
         ilen_in   = 4'd0;
         held_in   = 8'd0;
      end else begin
         // start a new token from idle
         if (!taken && ch != " " && ch != 8'h09 && ch != 8'h0D) begin
            start_in = clamp(pos);
            if (ch == "#") begin
               mode_in = MODE_COMMENT;
            end else if (is_digit(ch)) begin
               mode_in = MODE_INT;
            end else if (is_alpha(ch) || ch == "_") begin
               mode_in = MODE_IDENT;
               cand_in = feed('1, 4'd0, ch);
               ilen_in = 4'd1;
            end else if (ch == 8'h0A) begin
               line_in = (line_ff < LINE_LIMIT) ? line_ff + 20'd1 : line_ff;
               res[n[1:0]] = mk(KIND_NEWLINE, ERR_NONE, start_field(clamp(pos)), 21'd1,
                                line_in);
               n = n + 3'd1;
            end else if (ch == "&" || ch == "|" || ch == "=" || ch == "!" || ch == "<"
                         || ch == ">") begin
               mode_in = MODE_OP;
               held_in = ch;
            end else if (ch == "\"") begin
               mode_in = MODE_STRING;
            end else if (sk[6]) begin
               res[n[1:0]] = mk(sk[5:0], ERR_NONE, start_field(clamp(pos)), 21'd1, line_ff);
               n = n + 3'd1;
            end else begin
               res[n[1:0]] = mk(KIND_ERROR, ERR_UNEXPECTED, start_field(clamp(pos)),
                                21'd1, line_ff);
               n = n + 3'd1;
            end
         end
         offset_in = (offset_ff < OFFSET_MAX) ? offset_ff + OW'(1) : offset_ff;
      end

      // flag the final beat of this byte
      if (n != 3'd0) res[n[1:0] - 2'd1].last_of_run = 1'b1;

      scan_out.count = n[1:0];
      scan_out.res   = res;
   end

   // scanner state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         start_ff  <= '0;
         offset_ff <= '0;
         line_ff   <= 20'd1;
         cand_ff   <= '1;
         ilen_ff   <= 4'd0;
         held_ff   <= 8'd0;
      end else if (take) begin
         mode_ff   <= mode_in;
         start_ff  <= start_in;
         offset_ff <= offset_in;
         line_ff   <= line_in;
         cand_ff   <= cand_in;
         ilen_ff   <= ilen_in;
         held_ff   <= held_in;
      end
   end

   // line count never drops to zero
   assert property (@(posedge clock) disable iff (reset) line_ff != 20'd0)
      else $error("line count zero");
   // an accepted end byte always leaves the scanner idle at offset zero
   assert property (@(posedge clock) disable iff (reset)
                    take && (end_of_source || ch == 8'd0) |=> mode_ff == MODE_IDLE
                    && offset_ff == '0)
      else $error("end of source did not reset scanner");
   // offset never passes the source size
   assert property (@(posedge clock) disable iff (reset) offset_ff <= OFFSET_MAX)
      else $error("offset overflow");

endmodule

@@ src/source_tokenizer.sv @@
// source tokenizer top level: scanner plus result queue
// result beats are written to the queue when the byte that closes their token is accepted
// throughput: one byte per cycle; each byte yields up to three result beats, drained one per cycle
// while rsp_stall is low, from a four-entry queue, so input stalls while more than one beat waits
// reset: synchronous, clears scanner to idle at offset zero and line one, empties queue
module source_tokenizer #(
   parameter int SOURCE_BYTES  = 1048576,
   parameter int KEYWORD_COUNT = 19
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_end_of_source,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_token_kind,
   output logic [1:0]  rsp_error_code,
   output logic [19:0] rsp_start_offset,
   output logic [20:0] rsp_token_length,
   output logic [19:0] rsp_line_number,
   output logic        rsp_last_of_run
);
   import stok_pkg::*;

   localparam int DEPTH = 4;

   scan_out_type scan_out;
   result_type   queue_ff [DEPTH];
   logic [1:0]   head_ff, head_in;
   logic [1:0]   tail_ff, tail_in;
   logic [2:0]   count_ff, count_in;
   logic         take;
   logic         pop;
   result_type   head_beat;

   assign req_stall = count_ff > 3'(DEPTH - MAX_RESULTS);
   assign take      = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   stok_scan #(
      .SOURCE_BYTES  (SOURCE_BYTES),
      .KEYWORD_COUNT (KEYWORD_COUNT)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .ch            (req_ch),
      .end_of_source (req_end_of_source),
      .scan_out      (scan_out)
   );

   // queue pointers
   always_comb begin
      head_in  = pop ? head_ff + 2'd1 : head_ff;
      tail_in  = take ? tail_ff + scan_out.count : tail_ff;
      count_in = count_ff + (take ? 3'(scan_out.count) : 3'd0) - (pop ? 3'd1 : 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 2'd0;
         tail_ff  <= 2'd0;
         count_ff <= 3'd0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // queue storage, up to three beats written per cycle
   always_ff @(posedge clock) begin
      if (take) begin
         for (int k = 0; k < MAX_RESULTS; k++) begin
            if (2'(k) < scan_out.count) queue_ff[tail_ff + 2'(k)] <= scan_out.res[k];
         end
      end
   end

   // result beat at the head
   assign head_beat        = queue_ff[head_ff];
   assign rsp_valid        = count_ff != 3'd0;
   assign rsp_token_kind   = head_beat.token_kind;
   assign rsp_error_code   = head_beat.error_code;
   assign rsp_start_offset = head_beat.start_offset;
   assign rsp_token_length = head_beat.token_length;
   assign rsp_line_number  = head_beat.line_number;
   assign rsp_last_of_run  = head_beat.last_of_run;

   // queue never overfills
   assert property (@(posedge clock) disable iff (reset) count_ff <= 3'(DEPTH))
      else $error("result queue overflow");
   // every accepted end byte yields at least its eof beat
   assert property (@(posedge clock) disable iff (reset)
                    take && req_end_of_source |-> scan_out.count != 2'd0)
      else $error("end byte produced no beat");
   // pointers and count stay consistent
   assert property (@(posedge clock) disable iff (reset)
                    count_ff[1:0] == tail_ff - head_ff)
      else $error("queue pointer mismatch");

endmodule

@@ tb/sv/tokenizer_checker.sv @@
// token checker: watches both channels, predicts tokens and compares result beats
`timescale 1ns / 1ps
module tokenizer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_end_of_source,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [5:0]  rsp_token_kind,
   input  logic [1:0]  rsp_error_code,
   input  logic [19:0] rsp_start_offset,
   input  logic [20:0] rsp_token_length,
   input  logic [19:0] rsp_line_number,
   input  logic        rsp_last_of_run,
   output int          fail_count,
   output int          tokens_pending
);
   import stok_pkg::*;

   localparam int SRC_BYTES = 1048576;
   localparam int KW_SLOTS  = 19;

   // keyword spellings and kinds, kept apart from the package tables
   string      kw_word [18] = '{"else", "bool", "fn", "false", "float", "if", "impl",
      "implement", "int", "interface", "list", "map", "string", "struct", "null",
      "return", "true", "while"};
   logic [5:0] kw_code [18] = '{6'd15, 6'd9, 6'd12, 6'd3, 6'd7, 6'd14, 6'd19, 6'd20,
      6'd6, 6'd18, 6'd10, 6'd11, 6'd8, 6'd17, 6'd4, 6'd13, 6'd2, 6'd16};

   result_type token_queue [$];
   result_type beat_buf [$];

   mode_type    mode;
   logic [19:0] tok_start;
   logic [20:0] offset;
   logic [19:0] line;
   logic [31:0] candidates;
   logic [3:0]  id_len;
   logic [7:0]  held_op;

   assign tokens_pending = token_queue.size();

   function automatic logic [20:0] span_of(logic [20:0] hi, logic [20:0] lo);
      logic [20:0] d;
      d = hi > lo ? hi - lo : 21'd0;
      return d > SRC_BYTES ? 21'(SRC_BYTES) : d;
   endfunction

   function automatic logic [19:0] start_clamp(logic [20:0] p);
      return p > SRC_BYTES - 1 ? 20'(SRC_BYTES - 1) : p[19:0];
   endfunction

   function automatic logic digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   task automatic push_token(logic [5:0] k, logic [1:0] e, logic [19:0] s, logic [20:0] l);
      result_type r;
      if (beat_buf.size() >= MAX_RESULTS) return;
      r.token_kind = k;
      r.error_code = e;
      r.start_offset = s;
      r.token_length = l;
      r.line_number = line;
      r.last_of_run = 1'b0;
      beat_buf.push_back(r);
   endtask

   task automatic clear_state();
      mode = MODE_IDLE;
      tok_start = '0;
      offset = '0;
      line = 20'd1;
      candidates = (32'd1 << KW_SLOTS) - 1;
      id_len = '0;
      held_op = '0;
   endtask

   task automatic feed_ident(logic [7:0] c);
      for (int i = 0; i < KW_SLOTS && i < 32; i++) begin
         if (i >= 18 || id_len >= kw_word[i].len() || kw_word[i][id_len] != c)
            candidates[i] = 1'b0;
      end
      id_len = id_len == 4'd15 ? 4'd15 : id_len + 4'd1;
   endtask

   function automatic logic [5:0] ident_code();
      for (int i = 0; i < 18 && i < KW_SLOTS; i++)
         if (candidates[i] && kw_word[i].len() == id_len) return kw_code[i];
      return KIND_IDENT;
   endfunction

   function automatic logic [5:0] one_op(logic [7:0] h);
      case (h)
         "=": return KIND_EQ;
         "!": return KIND_NOT;
         "<": return KIND_LT;
         default: return KIND_GT;
      endcase
   endfunction

   function automatic logic [5:0] two_op(logic [7:0] h);
      case (h)
         "=": return KIND_EQEQ;
         "!": return KIND_BANGEQ;
         "<": return KIND_LTEQ;
         default: return KIND_GTEQ;
      endcase
   endfunction

   function automatic logic [6:0] punct(logic [7:0] c);
      case (c)
         "(": return {1'b1, KIND_LPAREN};
         ")": return {1'b1, KIND_RPAREN};
         "{": return {1'b1, KIND_LBRACE};
         "}": return {1'b1, KIND_RBRACE};
         "[": return {1'b1, KIND_LBRACKET};
         "]": return {1'b1, KIND_RBRACKET};
         ",": return {1'b1, KIND_COMMA};
         ":": return {1'b1, KIND_COLON};
         ".": return {1'b1, KIND_DOT};
         "+": return {1'b1, KIND_PLUS};
         "-": return {1'b1, KIND_MINUS};
         "*": return {1'b1, KIND_STAR};
         "/": return {1'b1, KIND_SLASH};
         "%": return {1'b1, KIND_PERCENT};
         default: return 7'd0;
      endcase
   endfunction

   // close the open token ending just before pos
   task automatic close_token(logic [20:0] pos);
      logic [20:0] dot;
      case (mode)
         MODE_INT, MODE_FRAC:
            push_token(KIND_NUMBER, ERR_NONE, tok_start, span_of(pos, tok_start));
         MODE_DOT: begin
            dot = pos > 0 ? pos - 21'd1 : 21'd0;
            push_token(KIND_NUMBER, ERR_NONE, tok_start, span_of(dot, tok_start));
            push_token(KIND_DOT, ERR_NONE, start_clamp(dot), 21'd1);
         end
         MODE_IDENT:
            push_token(ident_code(), ERR_NONE, tok_start, span_of(pos, tok_start));
         MODE_STRING:
            push_token(KIND_ERROR, ERR_STRING, tok_start, span_of(pos, tok_start));
         MODE_OP:
            if (held_op == "&") push_token(KIND_ERROR, ERR_AMP, tok_start, 21'd1);
            else if (held_op == "|") push_token(KIND_ERROR, ERR_BAR, tok_start, 21'd1);
            else push_token(one_op(held_op), ERR_NONE, tok_start, 21'd1);
         default: ;
      endcase
      mode = MODE_IDLE;
   endtask

   // byte seen between tokens
   task automatic begin_token(logic [7:0] c, logic [20:0] pos);
      logic [6:0] pk;
      if (c == " " || c == 8'h09 || c == 8'h0d) return;
      tok_start = start_clamp(pos);
      if (c == "#") mode = MODE_COMMENT;
      else if (digit(c)) mode = MODE_INT;
      else if (letter(c) || c == "_") begin
         mode = MODE_IDENT;
         candidates = (32'd1 << KW_SLOTS) - 1;
         id_len = '0;
         feed_ident(c);
      end else if (c == 8'h0a) begin
         if (line < LINE_LIMIT) line++;
         push_token(KIND_NEWLINE, ERR_NONE, tok_start, 21'd1);
      end else if (c == "&" || c == "|" || c == "=" || c == "!" || c == "<" || c == ">") begin
         mode = MODE_OP;
         held_op = c;
      end else if (c == "\"") mode = MODE_STRING;
      else begin
         pk = punct(c);
         if (pk[6]) push_token(pk[5:0], ERR_NONE, tok_start, 21'd1);
         else push_token(KIND_ERROR, ERR_UNEXPECTED, tok_start, 21'd1);
      end
   endtask

   // predict the tokens caused by one input beat
   task automatic scan_byte(logic [7:0] c, logic eos);
      logic [20:0] pos;
      logic taken;
      pos = offset;
      taken = 1'b0;
      beat_buf.delete();
      if (eos || c == 8'd0) begin
         close_token(pos);
         push_token(KIND_EOF, ERR_NONE, start_clamp(pos), 21'd0);
         clear_state();
      end else begin
         case (mode)
            MODE_COMMENT:
               if (c != 8'h0a) taken = 1'b1;
               else mode = MODE_IDLE;
            MODE_INT:
               if (digit(c)) taken = 1'b1;
               else if (c == ".") begin
                  mode = MODE_DOT;
                  taken = 1'b1;
               end
            MODE_DOT:
               if (digit(c)) begin
                  mode = MODE_FRAC;
                  taken = 1'b1;
               end
            MODE_FRAC:
               if (digit(c)) taken = 1'b1;
            MODE_IDENT:
               if (letter(c) || digit(c) || c == "_") begin
                  feed_ident(c);
                  taken = 1'b1;
               end
            MODE_STRING: begin
               taken = 1'b1;
               if (c == "\"") begin
                  push_token(KIND_STRING, ERR_NONE, tok_start, span_of(pos + 21'd1, tok_start));
                  mode = MODE_IDLE;
               end else if (c == 8'h0a && line < LINE_LIMIT) line++;
            end
            MODE_OP:
               if (held_op == "&" || held_op == "|") begin
                  if (c == held_op) begin
                     push_token(c == "&" ? KIND_AND : KIND_OR, ERR_NONE, tok_start, 21'd2);
                     mode = MODE_IDLE;
                     taken = 1'b1;
                  end
               end else if (c == "=") begin
                  push_token(two_op(held_op), ERR_NONE, tok_start, 21'd2);
                  mode = MODE_IDLE;
                  taken = 1'b1;
               end
            default: mode = MODE_IDLE;
         endcase
         if (!taken) begin
            close_token(pos);
            begin_token(c, pos);
         end
         if (offset < SRC_BYTES) offset++;
      end
      if (beat_buf.size() > 0) beat_buf[beat_buf.size() - 1].last_of_run = 1'b1;
      foreach (beat_buf[i]) token_queue.push_back(beat_buf[i]);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   // compare result beats, then predict from input beats on the same edge
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         clear_state();
         token_queue.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (token_queue.size() == 0) begin
               $error("result beat with no token expected");
               fail_count++;
            end else begin
               want = token_queue.pop_front();
               check_field("token_kind", 32'(want.token_kind), 32'(rsp_token_kind));
               check_field("error_code", 32'(want.error_code), 32'(rsp_error_code));
               check_field("start_offset", 32'(want.start_offset), 32'(rsp_start_offset));
               check_field("token_length", 32'(want.token_length), 32'(rsp_token_length));
               check_field("line_number", 32'(want.line_number), 32'(rsp_line_number));
               check_field("last_of_run", 32'(want.last_of_run), 32'(rsp_last_of_run));
            end
         end
         if (req_valid && !req_stall) scan_byte(req_ch, req_end_of_source);
      end
   end
endmodule

@@ tb/sv/tb.sv @@
// testbench top: drives source bytes with random gaps and stalls, gives the verdict
`timescale 1ns / 1ps
module tb;
   import stok_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_ch;
   logic        req_end_of_source;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [5:0]  rsp_token_kind;
   logic [1:0]  rsp_error_code;
   logic [19:0] rsp_start_offset;
   logic [20:0] rsp_token_length;
   logic [19:0] rsp_line_number;
   logic        rsp_last_of_run;
   int          fail_count;
   int          tokens_pending;
   int          send_idle_pct;
   int          recv_idle_pct;

   source_tokenizer DUT (.*);

   tokenizer_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver stall
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   // one beat, held until accepted; leaves valid high when back-to-back
   task automatic send_beat(logic [7:0] c, logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch <= c;
      req_end_of_source <= eos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
   endtask

   // pick a fragment: mostly well-formed tokens, sometimes raw noise
   function automatic string random_piece();
      string pieces [24] = '{"else ", "implement", "interface", "struct", "while",
         "impl ", "true", "null ", "fnx ", "x_1", "12.5", "7.", "42 ", "\"ab\"",
         "\"a\nb\"", "&&", "||", "<=", ">=", "!=", "==", "# note\n", "\n", "( ) , :"};
      string s;
      int r;
      r = $urandom_range(9);
      if (r < 7) return pieces[$urandom_range(23)];
      s = " ";
      s[0] = 8'($urandom_range(1, 255));
      return s;
   endfunction

   initial begin
      int count;
      string p;
      reset = 1'b1;
      req_valid = 1'b0;
      req_ch = 8'd0;
      req_end_of_source = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: keywords, operators, numbers, strings, errors, end cases
      send_text("else implement interface struct while x\t1.5\r");
      send_text("7.a 3.\"s\n\"& |=!<>");
      send_beat(8'hff, 1'b0);
      send_beat(8'h01, 1'b0);
      send_beat("&", 1'b0);
      send_beat(8'h00, 1'b0);
      send_text("4.");
      send_beat(8'h55, 1'b1);
      send_text("\"open");
      send_beat(8'haa, 1'b1);

      // pause until every token has come out
      req_valid <= 1'b0;
      @(posedge clock);
      while (tokens_pending != 0) @(posedge clock);

      // random: three idling phases
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = ph == 0 ? 31 : (ph == 1 ? 60 : 0);
         recv_idle_pct = ph == 0 ? 60 : (ph == 1 ? 31 : 0);
         count = 0;
         while (count < 33) begin
            p = random_piece();
            send_text(p);
            count += p.len();
            if ($urandom_range(15) == 0) begin
               send_beat(8'($urandom_range(255)), 1'b1);
               count++;
            end
         end
      end
      send_beat(8'h00, 1'b1);
      req_valid <= 1'b0;

      while (tokens_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end
endmodule

@@ sim.f @@
src/stok_pkg.sv
src/stok_scan.sv
src/source_tokenizer.sv
tb/sv/tokenizer_checker.sv
tb/sv/tb.sv
